### sv/rle_dec_pkg.sv
package rle_dec_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 10;
  localparam int unsigned DigitsW = 2;

  localparam logic [ByteW-1:0]   SepReset  = 8'd83;
  localparam logic [ByteW-1:0]   DigitZero = 8'd48;
  localparam logic [ByteW-1:0]   Radix     = 8'd10;
  localparam logic [DigitsW-1:0] MaxDigits = 2'd3;

  typedef enum logic [2:0] {
    PhSymbol,
    PhSecond,
    PhLoneSep,
    PhCount,
    PhSkipTwo,
    PhSkipOne,
    PhDone,
    PhError
  } phase_e;

  typedef struct packed {
    logic             end_of_stream;
    logic [ByteW-1:0] in_byte;
  } item_t;

  typedef struct packed {
    logic              done_res;
    logic              error;
    logic [CountW-1:0] repeat_count;
    logic [ByteW-1:0]  out_byte;
  } result_t;

endpackage

### sv/rle_dec_in_reg.sv
module rle_dec_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  rle_dec_pkg::item_t   item_i,
  input  logic                 take_i,
  output logic                 fire_o,
  output rle_dec_pkg::item_t   item_o
);
  import rle_dec_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign fire_o  = valid_q && take_i;
  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;
  assign item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (fire_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

endmodule

### sv/rle_dec_core.sv
module rle_dec_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rle_dec_pkg::ByteW-1:0]     cfg_wdata_i,
  input  logic                              fire_i,
  input  rle_dec_pkg::item_t                item_i,
  output logic                              res_valid_o,
  output rle_dec_pkg::result_t              res_o
);
  import rle_dec_pkg::*;

  phase_e              phase_q, phase_d;
  logic [ByteW-1:0]    sep_q, sep_d;
  logic [ByteW-1:0]    held_q, held_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [DigitsW-1:0]  digits_q, digits_d;

  logic [ByteW-1:0]    b;
  logic                eos;
  logic                halted;
  logic                is_digit;
  logic [3:0]          digit_val;
  logic [CountW-1:0]   times_ten;
  logic [CountW-1:0]   acc;
  logic [DigitsW-1:0]  digits_inc;

  assign b          = item_i.in_byte;
  assign eos        = item_i.end_of_stream;
  assign halted     = (phase_q == PhDone) || (phase_q == PhError);
  assign is_digit   = (b >= DigitZero) && (b < DigitZero + Radix);
  // The digit value only matters when the byte is a digit, where it fits in four bits.
  assign digit_val  = b[3:0] - DigitZero[3:0];
  // Multiply by ten as 8x + 2x; the count wraps at its width.
  assign times_ten  = (count_q << 3) + (count_q << 1);
  assign acc        = times_ten + {{(CountW-4){1'b0}}, digit_val};
  assign digits_inc = digits_q + 2'd1;
  assign sep_d      = cfg_we_i ? cfg_wdata_i : sep_q;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (fire_i && !halted) begin
      if (eos) begin
        if (phase_q == PhSymbol || phase_q == PhSkipOne || phase_q == PhSkipTwo) begin
          phase_d = PhDone;
        end else begin
          phase_d = PhError;
        end
      end else begin
        case (phase_q)
          PhSymbol: phase_d = PhSecond;
          PhSecond: begin
            if (b == held_q) begin
              phase_d = PhCount;
            end else if (b == sep_q) begin
              phase_d = PhLoneSep;
            end else begin
              phase_d = PhError;
            end
          end
          PhLoneSep: phase_d = (b == sep_q) ? PhSymbol : PhError;
          PhCount: begin
            if (digits_q != '0 && b == sep_q) begin
              phase_d = PhSkipOne;
            end else if (!is_digit) begin
              phase_d = PhError;
            end else if (digits_inc == MaxDigits) begin
              phase_d = PhSkipTwo;
            end
          end
          PhSkipTwo: phase_d = PhSkipOne;
          PhSkipOne: phase_d = PhSymbol;
          default:   phase_d = PhError;
        endcase
      end
    end
  end

  // Results and datapath registers.
  always_comb begin
    held_d      = held_q;
    count_d     = count_q;
    digits_d    = digits_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (fire_i && !halted) begin
      if (eos) begin
        res_valid_o = 1'b1;
        if (phase_q == PhSymbol || phase_q == PhSkipOne || phase_q == PhSkipTwo) begin
          res_o.done_res = 1'b1;
        end else begin
          res_o.error = 1'b1;
        end
      end else begin
        case (phase_q)
          PhSymbol: begin
            held_d             = b;
            res_valid_o        = 1'b1;
            res_o.out_byte     = b;
            res_o.repeat_count = CountW'(1);
          end
          PhSecond: begin
            if (b == held_q) begin
              count_d            = '0;
              digits_d           = '0;
              res_valid_o        = 1'b1;
              res_o.out_byte     = b;
              res_o.repeat_count = CountW'(1);
            end else if (b != sep_q) begin
              res_valid_o = 1'b1;
              res_o.error = 1'b1;
            end
          end
          PhLoneSep: begin
            if (b != sep_q) begin
              res_valid_o = 1'b1;
              res_o.error = 1'b1;
            end
          end
          PhCount: begin
            if (digits_q != '0 && b == sep_q) begin
              res_valid_o        = (count_q != '0);
              res_o.out_byte     = held_q;
              res_o.repeat_count = count_q;
            end else if (!is_digit) begin
              res_valid_o = 1'b1;
              res_o.error = 1'b1;
            end else begin
              count_d  = acc;
              digits_d = digits_inc;
              if (digits_inc == MaxDigits) begin
                res_valid_o        = (acc != '0);
                res_o.out_byte     = held_q;
                res_o.repeat_count = acc;
              end
            end
          end
          PhSkipTwo, PhSkipOne: begin
            res_valid_o = 1'b0;
          end
          default: begin
            res_valid_o = 1'b1;
            res_o.error = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSymbol;
      sep_q    <= SepReset;
      held_q   <= '0;
      count_q  <= '0;
      digits_q <= '0;
    end else begin
      phase_q  <= phase_d;
      sep_q    <= sep_d;
      held_q   <= held_d;
      count_q  <= count_d;
      digits_q <= digits_d;
    end
  end

endmodule

### sv/rle_dec_out_buf.sv
module rle_dec_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rle_dec_pkg::result_t  data_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  logic                  pop_ready_i,
  output rle_dec_pkg::result_t  data_o
);
  import rle_dec_pkg::*;

  logic [1:0] count_q, count_d;
  result_t    head_q, head_d;
  result_t    skid_q, skid_d;
  logic       pop;

  // Ready depends only on the fill count, so no path runs from the
  // downstream ready to the upstream ready.
  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = head_q;
  assign pop     = valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    skid_d  = skid_q;
    case (count_q)
      2'd0: begin
        if (push_i) begin
          head_d  = data_i;
          count_d = 2'd1;
        end
      end
      2'd1: begin
        if (push_i && pop) begin
          head_d = data_i;
        end else if (push_i) begin
          skid_d  = data_i;
          count_d = 2'd2;
        end else if (pop) begin
          count_d = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_d  = skid_q;
          count_d = 2'd1;
        end
      end
      default: count_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

### sv/rle_text_decoder.sv
// Run-length text decoder. One encoded byte enters per request on the slave
// side and every byte is taken at one per cycle while the result side keeps
// up; a request gives at most one result, which carries a symbol with its
// repeat count, or an error or end flag. The rate is set by the input
// register feeding the phase logic and the two-entry result buffer; when
// that buffer is full, input stalls until a result is taken. After an error
// or a clean end the block takes bytes but gives no result until reset. The
// user must write the separator byte through cfg_we_i and cfg_wdata_i only
// while no request is in flight; the block itself does not enforce this. It resets to 'S'.
module rle_text_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [17:8] repeat_count, rest zero
  output logic [1:0]  m_axis_tuser    // [0] error, [1] done_res
);
  import rle_dec_pkg::*;

  item_t   in_item;
  item_t   stage_item;
  logic    stage_fire;
  logic    buf_ready;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.in_byte       = s_axis_tdata;
  assign in_item.end_of_stream = s_axis_tlast;

  rle_dec_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .take_i  (buf_ready),
    .fire_o  (stage_fire),
    .item_o  (stage_item)
  );

  rle_dec_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (stage_fire),
    .item_i      (stage_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rle_dec_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .ready_o     (buf_ready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_res)
  );

  assign m_axis_tdata = {6'b0, out_res.repeat_count, out_res.out_byte};
  assign m_axis_tuser = {out_res.done_res, out_res.error};

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import rle_dec_pkg::*;

  localparam int unsigned HalfPeriod     = 6;
  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned PhaseItems     = 190;
  localparam int unsigned LongHoldAt     = 500;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned NoiseItems     = 16;

  typedef enum int {
    EndClean,
    EndWhileSkipping,
    EndInsideToken,
    BadFirstSep,
    BadSecondSep,
    BadCountChar
  } ending_e;

  // Tracks the decoder state and holds the results still owed by the block.
  class rle_result_tracker;
    logic [ByteW-1:0]   separator;
    phase_e             phase;
    logic [ByteW-1:0]   held_symbol;
    logic [CountW-1:0]  run_count;
    logic [DigitsW-1:0] digits_seen;
    bit                 halted;
    result_t            decoded_q[$];
    int unsigned        requests;
    int unsigned        results;
    int unsigned        mismatches;
    int unsigned        max_count;

    function new();
      separator   = SepReset;
      phase       = PhSymbol;
      held_symbol = '0;
      run_count   = '0;
      digits_seen = '0;
      halted      = 1'b0;
      requests    = 0;
      results     = 0;
      mismatches  = 0;
      max_count   = 0;
    endfunction

    function void set_separator(logic [ByteW-1:0] value);
      separator = value;
    endfunction

    function bit raise_fault(output result_t r);
      r       = '0;
      r.error = 1'b1;
      phase   = PhError;
      halted  = 1'b1;
      return 1'b1;
    endfunction

    // A run whose count came out as zero produces nothing.
    function bit close_run(phase_e next_phase, output result_t r);
      r     = '0;
      phase = next_phase;
      if (run_count == '0) return 1'b0;
      r.out_byte     = held_symbol;
      r.repeat_count = run_count;
      return 1'b1;
    endfunction

    function bit decode_byte(item_t it, output result_t r);
      logic [ByteW-1:0] b;
      bit               is_digit;
      b        = it.in_byte;
      is_digit = (b >= DigitZero) && (b < DigitZero + Radix);
      r        = '0;
      if (halted) return 1'b0;
      if (it.end_of_stream) begin
        if (phase inside {PhSymbol, PhSkipOne, PhSkipTwo}) begin
          phase      = PhDone;
          halted     = 1'b1;
          r.done_res = 1'b1;
          return 1'b1;
        end
        return raise_fault(r);
      end
      case (phase)
        PhSymbol: begin
          held_symbol    = b;
          phase          = PhSecond;
          r.out_byte     = b;
          r.repeat_count = CountW'(1);
          return 1'b1;
        end
        PhSecond: begin
          if (b == held_symbol) begin
            run_count      = '0;
            digits_seen    = '0;
            phase          = PhCount;
            r.out_byte     = b;
            r.repeat_count = CountW'(1);
            return 1'b1;
          end
          if (b == separator) begin
            phase = PhLoneSep;
            return 1'b0;
          end
          return raise_fault(r);
        end
        PhLoneSep: begin
          if (b == separator) begin
            phase = PhSymbol;
            return 1'b0;
          end
          return raise_fault(r);
        end
        PhCount: begin
          if (digits_seen != '0 && b == separator) return close_run(PhSkipOne, r);
          if (!is_digit) return raise_fault(r);
          run_count   = run_count * Radix + (b - DigitZero);
          digits_seen = digits_seen + 1'b1;
          if (digits_seen == MaxDigits) return close_run(PhSkipTwo, r);
          return 1'b0;
        end
        PhSkipTwo: begin
          phase = PhSkipOne;
          return 1'b0;
        end
        PhSkipOne: begin
          phase = PhSymbol;
          return 1'b0;
        end
        default: return raise_fault(r);
      endcase
    endfunction

    function void note_request(item_t it);
      result_t r;
      requests++;
      if (decode_byte(it, r)) decoded_q.push_back(r);
    endfunction

    function void report(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected byte %02h count %0d err %0b done %0b,",
                 $time, what, want.out_byte, want.repeat_count, want.error, want.done_res,
                 " got byte %02h count %0d err %0b done %0b",
                 got.out_byte, got.repeat_count, got.error, got.done_res);
    endfunction

    function void check_result(logic [23:0] data, logic [1:0] user);
      result_t got;
      result_t want;
      got.out_byte     = data[7:0];
      got.repeat_count = data[17:8];
      got.error        = user[0];
      got.done_res     = user[1];
      results++;
      if (decoded_q.size() == 0) begin
        report("result with nothing pending", '0, got);
        return;
      end
      want = decoded_q.pop_front();
      if (got.out_byte !== want.out_byte || got.repeat_count !== want.repeat_count ||
          got.error !== want.error || got.done_res !== want.done_res || data[23:18] !== '0)
        report("result mismatch", want, got);
      if (!want.error && !want.done_res && want.repeat_count > max_count)
        max_count = want.repeat_count;
    endfunction

    function int unsigned pending();
      return decoded_q.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] in_byte
  logic        s_axis_tlast  = 1'b0;   // end_of_stream
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [23:0] m_axis_tdata;           // [7:0] out_byte, [17:8] repeat_count
  logic [1:0]  m_axis_tuser;           // [0] error, [1] done_res

  rle_result_tracker ledger = new();

  logic [7:0]  sep_now       = SepReset;
  int unsigned src_gap_pct   = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned stall_left    = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;
  int unsigned cycles        = 0;
  int unsigned settings_used = 0;
  ending_e     ending        = EndClean;

  rle_text_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results pending.",
               cycles, ledger.pending());
      $display("** rle_text_decoder: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      ledger.check_result(m_axis_tdata, m_axis_tuser);
  end

  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Result side: random stalls, plus one long hold-off once traffic is under way
  // so that the block backs up and stalls its input.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && ledger.requests >= LongHoldAt) begin
      hold_done = 1'b1;
      hold_left = LongHoldCycles - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left = pick_gap(snk_stall_pct);
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_byte(logic [7:0] b, logic eos = 1'b0);
    int unsigned gap;
    gap = pick_gap(src_gap_pct);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.note_request('{end_of_stream: eos, in_byte: b});
  endtask

  // Stops the source and lets every owed result, and any byte still inside
  // the block, work its way out.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_separator(logic [7:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sep_now = value;
    ledger.set_separator(value);
    settings_used++;
  endtask

  function automatic logic [7:0] other_byte(logic [7:0] a, logic [7:0] b);
    logic [7:0] v;
    do v = 8'($urandom); while (v == a || v == b);
    return v;
  endfunction

  // Only the first count digit may equal a digit-valued separator, since a
  // later one would close the count early.
  function automatic logic [7:0] count_digit(bit first);
    logic [7:0] d;
    do d = DigitZero + 8'($urandom_range(0, 9)); while (!first && d == sep_now);
    return d;
  endfunction

  function automatic logic [7:0] non_digit(logic [7:0] avoid);
    logic [7:0] v;
    do v = 8'($urandom); while ((v >= DigitZero && v < DigitZero + Radix) || v == avoid);
    return v;
  endfunction

  task automatic send_lone(logic [7:0] sym);
    push_byte(sym);
    push_byte(sep_now);
    push_byte(sep_now);
  endtask

  task automatic send_run(logic [7:0] sym, logic [7:0] d0, logic [7:0] d1, logic [7:0] d2,
                          int unsigned ndig);
    push_byte(sym);
    push_byte(sym);
    push_byte(d0);
    if (ndig > 1) push_byte(d1);
    if (ndig > 2) begin
      push_byte(d2);
      push_byte(8'($urandom));
      push_byte(8'($urandom));
    end else begin
      push_byte(sep_now);
      push_byte(8'($urandom));
    end
  endtask

  task automatic send_random_token();
    logic [7:0]  sym;
    int unsigned ndig;
    int unsigned pick;
    sym  = ($urandom_range(0, 7) == 0) ? sep_now : 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_lone(other_byte(sep_now, sep_now));
    end else begin
      ndig = (pick < 60) ? 1 : (pick < 82) ? 2 : 3;
      send_run(sym, count_digit(1'b1), count_digit(1'b0), count_digit(1'b0), ndig);
    end
  endtask

  task automatic end_stream(ending_e kind);
    logic [7:0] sym;
    sym = other_byte(sep_now, sep_now);
    case (kind)
      EndClean: push_byte(8'($urandom), 1'b1);
      EndWhileSkipping: begin
        push_byte(sym);
        push_byte(sym);
        push_byte(count_digit(1'b1));
        push_byte(count_digit(1'b0));
        push_byte(count_digit(1'b0));
        if ($urandom_range(0, 1) == 1) push_byte(8'($urandom));
        push_byte(8'($urandom), 1'b1);
      end
      EndInsideToken: begin
        push_byte(sym);
        case ($urandom_range(0, 2))
          0: ;
          1: push_byte(sep_now);
          default: begin
            push_byte(sym);
            push_byte(count_digit(1'b1));
          end
        endcase
        push_byte(8'($urandom), 1'b1);
      end
      BadFirstSep: begin
        push_byte(sym);
        push_byte(other_byte(sym, sep_now));
      end
      BadSecondSep: begin
        push_byte(sym);
        push_byte(sep_now);
        push_byte(other_byte(sep_now, sep_now));
      end
      default: begin
        push_byte(sym);
        push_byte(sym);
        if ($urandom_range(0, 1) == 1) begin
          push_byte(count_digit(1'b1));
          push_byte(non_digit(sep_now));
        end else begin
          push_byte(non_digit(DigitZero));
        end
      end
    endcase
  endtask

  initial begin
    logic [7:0]  seps [6];
    int unsigned target;
    seps = '{8'h00, 8'hFF, DigitZero + 8'd5, 8'($urandom), SepReset, 8'($urandom)};

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Separator left at its reset value: lone symbol, the largest count, a
    // run of the separator itself with a zero count, and a two-digit count.
    send_lone(8'h00);
    send_run(8'hFF, DigitZero + 8'd9, DigitZero + 8'd9, DigitZero + 8'd9, 3);
    send_run(SepReset, DigitZero, DigitZero, DigitZero, 1);
    send_run(8'h41, DigitZero + 8'd1, DigitZero + 8'd2, DigitZero, 2);

    for (int i = 0; i < 6; i++) begin
      write_separator(seps[i]);
      case (i % 3)
        0: begin
          src_gap_pct   = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_gap_pct   = 20;
          snk_stall_pct = 20;
        end
        default: begin
          src_gap_pct   = 50;
          snk_stall_pct = 50;
        end
      endcase
      target = ledger.requests + PhaseItems;
      while (ledger.requests < target) send_random_token();
    end

    // The block halts for good here, so the bytes after the ending must be ignored.
    ending = ending_e'($urandom_range(0, 5));
    end_stream(ending);
    repeat (NoiseItems) push_byte(8'($urandom), 1'($urandom));
    drain();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d requests, checked %0d results across %0d separator values;",
             ledger.requests, ledger.results, settings_used,
             " largest run %0d.", ledger.max_count);
    $display("Stream ended by %s; one output hold-off of %0d cycles; %0d mismatches.",
             ending.name(), LongHoldCycles, ledger.mismatches);
    if (ledger.mismatches == 0)
      $display("** rle_text_decoder: PASSED **");
    else
      $display("** rle_text_decoder: FAILED **");
    $finish;
  end

endmodule

### rle_text_decoder.f
sv/rle_dec_pkg.sv
sv/rle_dec_in_reg.sv
sv/rle_dec_core.sv
sv/rle_dec_out_buf.sv
sv/rle_text_decoder.sv
sim/tb.sv
